>>> hw/rtl/rtpp_pkg.sv
// Shared types and constants of the RGB triple text parser.
package rtpp_pkg;

   localparam int MAG_W = 9;
   localparam int ACC_W = 12;   // widest value of magnitude * 10 + digit

   localparam logic [MAG_W-1:0] MAG_SAT   = 9'd256;
   localparam logic [7:0]       VALUE_MAX = 8'd255;
   localparam logic [3:0]       RADIX     = 4'd10;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_BRACKET = 8'h5B;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   localparam logic [1:0] IDX_RED   = 2'd0;
   localparam logic [1:0] IDX_GREEN = 2'd1;
   localparam logic [1:0] IDX_BLUE  = 2'd2;
   localparam logic [1:0] IDX_END   = 2'd3;

   typedef enum logic [6:0] {
      PH_OPEN   = 7'b0000001,
      PH_LEAD   = 7'b0000010,
      PH_SIGN   = 7'b0000100,
      PH_DIGITS = 7'b0001000,
      PH_SEP    = 7'b0010000,
      PH_DONE   = 7'b0100000,
      PH_FAIL   = 7'b1000000
   } phase_type;

   typedef struct packed {
      phase_type        phase;
      logic [1:0]       idx;
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
   } state_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase: PH_OPEN, idx: IDX_RED, neg: 1'b0, mag: '0,
      red: '0, green: '0, blue: '0
   };

endpackage

>>> hw/rtl/rtpp_step.sv
// Next-state and result logic for one character or terminator request.
module rtpp_step (
   input  rtpp_pkg::state_type  cur,
   input  logic [7:0]           ch,
   input  logic                 term,
   output rtpp_pkg::state_type  nxt,
   output rtpp_pkg::result_type res
);
   import rtpp_pkg::*;

   logic             is_digit;
   logic             is_space;
   logic             is_sign;
   logic             is_skip_sep;
   logic [3:0]       digit;
   logic [ACC_W-1:0] acc;
   logic [7:0]       clamped;
   state_type        lead;
   state_type        fin;
   state_type        sep;

   assign is_digit    = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_space    = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
   assign is_sign     = (ch == CH_PLUS) || (ch == CH_MINUS);
   assign is_skip_sep = (ch == CH_SPACE) || (ch == CH_COMMA);
   assign digit       = ch[3:0];

   // mag * 10 + digit as two shifts and two adds
   assign acc = {cur.mag, 3'b000} + {2'b00, cur.mag, 1'b0} + {8'd0, digit};

   assign clamped = cur.neg ? 8'd0 : (cur.mag[MAG_W-1] ? VALUE_MAX : cur.mag[7:0]);

   // Where a number may begin
   always_comb begin
      lead     = cur;
      lead.neg = 1'b0;
      lead.mag = '0;
      if (is_space) begin
         lead.phase = PH_LEAD;
      end else if (is_sign) begin
         lead.neg   = (ch == CH_MINUS);
         lead.phase = PH_SIGN;
      end else if (is_digit) begin
         lead.mag   = {5'd0, digit};
         lead.phase = PH_DIGITS;
      end else begin
         lead.phase = PH_FAIL;
      end
   end

   // Store the finished number in its slot
   always_comb begin
      fin     = cur;
      fin.idx = cur.idx + 2'd1;
      unique case (cur.idx)
         IDX_RED:   fin.red   = clamped;
         IDX_GREEN: fin.green = clamped;
         default:   fin.blue  = clamped;
      endcase
   end

   // Separator skip after a finished number, or done after the third
   always_comb begin
      sep = fin;
      if (fin.idx == IDX_END) begin
         sep.phase = PH_DONE;
      end else if (is_skip_sep) begin
         sep.phase = PH_SEP;
      end else begin
         sep.phase = lead.phase;
         sep.neg   = lead.neg;
         sep.mag   = lead.mag;
      end
   end

   always_comb begin
      nxt = cur;
      res = '0;
      if (term) begin
         nxt = STATE_RESET;
         if ((cur.phase == PH_DIGITS) && (cur.idx == IDX_BLUE)) begin
            res = '{ok: 1'b1, red: cur.red, green: cur.green, blue: clamped};
         end else if (cur.phase == PH_DONE) begin
            res = '{ok: 1'b1, red: cur.red, green: cur.green, blue: cur.blue};
         end
      end else begin
         unique case (cur.phase)
            PH_OPEN: begin
               if ((ch != CH_SPACE) && (ch != CH_BRACKET)) nxt = lead;
            end
            PH_LEAD: nxt = lead;
            PH_SIGN: begin
               if (is_digit) begin
                  nxt.mag   = {5'd0, digit};
                  nxt.phase = PH_DIGITS;
               end else begin
                  nxt.phase = PH_FAIL;
               end
            end
            PH_DIGITS: begin
               if (is_digit) begin
                  nxt.mag = (acc > {3'd0, MAG_SAT}) ? MAG_SAT : acc[MAG_W-1:0];
               end else begin
                  nxt = sep;
               end
            end
            PH_SEP: begin
               if (is_skip_sep) nxt.phase = PH_SEP;
               else             nxt = lead;
            end
            PH_DONE: nxt = cur;
            default: nxt.phase = PH_FAIL;
         endcase
      end
   end

endmodule

>>> hw/rtl/rgb_triple_text_parser_core.sv
// Top level of the RGB triple text parser: request register, parse state, result register.
//
//  channel | direction | ports                                   | moves
//  --------+-----------+-----------------------------------------+---------------------------
//  req     | in        | req_valid req_ready req_ch              | one character or
//          |           | req_terminator                          | terminator request
//  rsp     | out       | rsp_valid rsp_ready rsp_ok rsp_red      | one result per
//          |           | rsp_green rsp_blue                      | terminator request
//
// One request per cycle while no terminator waits on an untaken result: a request is
// held in the request register and from there updates the parse state, while a
// terminator's result loads the result register, which drives rsp_valid.
// Synchronous active-high reset clears the parse state and both valid flags.
// A terminator waits in the request register only while a result is held and not taken;
// characters keep flowing past a waiting result, and nothing is taken behind a stalled one.
module rgb_triple_text_parser_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_terminator,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_ok,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue
);
   import rtpp_pkg::*;

   // request register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;
   logic       in_term_ff;

   // parse state
   state_type  state_ff, state_in;
   state_type  step_nxt;
   result_type step_res;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   logic advance;
   logic load_rsp;

   rtpp_step u_step (
      .cur  (state_ff),
      .ch   (in_ch_ff),
      .term (in_term_ff),
      .nxt  (step_nxt),
      .res  (step_res)
   );

   // A terminator may only move on when the result register can take its result.
   assign advance   = in_valid_ff && (!in_term_ff || !rsp_valid_ff || rsp_ready);
   assign load_rsp  = advance && in_term_ff;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign state_in     = advance ? step_nxt : state_ff;
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff   <= req_ch;
         in_term_ff <= req_terminator;
      end
      if (load_rsp) rsp_ff <= step_res;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ff.ok;
   assign rsp_red   = rsp_ff.red;
   assign rsp_green = rsp_ff.green;
   assign rsp_blue  = rsp_ff.blue;

   // A failed parse reports all colors as zero.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.ok |->
         (rsp_ff.red == 8'd0) && (rsp_ff.green == 8'd0) && (rsp_ff.blue == 8'd0))
      else $error("failed result carries nonzero color");

   // A terminator returns the parser to its opening state.
   a_term_resets: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (state_ff.phase == PH_OPEN) && (state_ff.idx == IDX_RED))
      else $error("parse state not cleared after terminator");

   // Back-pressure only comes from a terminator blocked by an unread result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && in_term_ff && rsp_valid_ff && !rsp_ready)
      else $error("request stalled without a blocked terminator");

   // Accumulated magnitude never passes its saturation point.
   a_mag_sat: assert property (@(posedge clock) disable iff (reset)
      state_ff.mag <= MAG_SAT)
      else $error("magnitude above saturation");

endmodule
